>>> rtl/core/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FFBTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define FFBTA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define FFBTA_ASSERT(lbl, clk, rstn, prop, msg)

`define FFBTA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

>>> rtl/core/ffbta_pkg.sv
package ffbta_pkg;

  localparam int unsigned HEAP_BYTES_DEF  = 65536;
  localparam int unsigned CHUNK_BYTES_DEF = 4096;

  localparam logic [31:0] MIN_BLOCK = 32'd16;
  localparam logic [31:0] PROLOGUE  = 32'd9;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LATCH,
    CMD_WALK_INIT,
    CMD_WALK_RD,
    CMD_WALK_STEP,
    CMD_GROW_HDR,
    CMD_GROW_EPI,
    CMD_MRG_RDP,
    CMD_MRG_RDN,
    CMD_MRG_CALC,
    CMD_TAG_HDR,
    CMD_TAG_FTR,
    CMD_HDR_RD,
    CMD_CARVE_CALC,
    CMD_SPLIT,
    CMD_FREE_LOAD,
    CMD_RESULT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    flag;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_zero;
    logic free_bad;
    logic walk_stop;
    logic walk_end;
    logic walk_fit;
    logic grow_fail;
    logic free_reject;
    logic split;
  } status_t;

  function automatic logic [31:0] init_word(input logic [31:0] idx, input logic [31:0] cr);
    logic [31:0] w;
    w = 32'd0;
    if (idx == 32'd1 || idx == 32'd2) begin
      w = PROLOGUE;
    end else if (idx == 32'd3) begin
      w = cr;
    end else if (idx == ((cr + 32'd8) >> 2)) begin
      w = cr;
    end else if (idx == ((cr + 32'd12) >> 2)) begin
      w = 32'd1;
    end
    return w;
  endfunction

endpackage

>>> rtl/core/ffbta_datapath.sv
module ffbta_datapath import ffbta_pkg::*; #(
  parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [15:0] req_i,
  input  logic [15:0] off_i,
  output status_t     status_o,
  output logic [15:0] payload_o,
  output logic        ok_o
);

  localparam int unsigned DEPTH = HEAP_BYTES / 4;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam logic [31:0] CR    = 32'((CHUNK_BYTES + 7) / 8 * 8);
  localparam logic [32:0] HEAP  = 33'(HEAP_BYTES);

  logic [31:0] mem [DEPTH];
  logic [31:0] raw_q;
  logic        oob_q;
  logic [31:0] rdata;

  logic [IW-1:0] clr_q;
  logic [NW-1:0] n_q;
  logic [31:0]   brk_q;
  logic [31:0]   bp_q, size_q, rest_q, pf_q;
  logic [16:0]   asize_q;
  logic          zero_q;
  logic [15:0]   res_q;
  logic          split_q;
  logic [15:0]   pay_q;
  logic          ok_q;

  logic [31:0] mem_addr, wdata;
  logic        rd_en, wr_en, in_range;
  logic [31:0] sz, ext, nsize, psize, bsize, rest;
  logic [16:0] asize_new;

  assign rdata = oob_q ? 32'd0 : raw_q;
  assign sz    = rdata & ~32'd7;
  assign ext   = (32'(asize_q) > CR) ? 32'(asize_q) : CR;
  assign psize = pf_q & ~32'd7;
  assign nsize = rdata & ~32'd7;
  assign bsize = rdata & ~32'd7;
  assign rest  = bsize - 32'(asize_q);
  assign asize_new = (req_i <= 16'd8) ? 17'd16 : ((17'(req_i) + 17'd15) & ~17'd7);

  always_comb begin
    mem_addr = 32'd0;
    wdata    = 32'd0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    unique case (cmd_i.op)
      CMD_CLEAR: begin
        mem_addr = 32'(clr_q) << 2;
        wdata    = init_word(32'(clr_q), CR);
        wr_en    = 1'b1;
      end
      CMD_WALK_RD, CMD_HDR_RD: begin
        mem_addr = bp_q - 32'd4;
        rd_en    = 1'b1;
      end
      CMD_GROW_HDR: begin
        mem_addr = brk_q - 32'd4;
        wdata    = ext;
        wr_en    = 1'b1;
      end
      CMD_GROW_EPI: begin
        mem_addr = bp_q + size_q - 32'd4;
        wdata    = 32'd1;
        wr_en    = 1'b1;
      end
      CMD_MRG_RDP: begin
        mem_addr = bp_q - 32'd8;
        rd_en    = 1'b1;
      end
      CMD_MRG_RDN: begin
        mem_addr = bp_q + size_q - 32'd4;
        rd_en    = 1'b1;
      end
      CMD_TAG_HDR: begin
        mem_addr = bp_q - 32'd4;
        wdata    = size_q | 32'(cmd_i.flag);
        wr_en    = 1'b1;
      end
      CMD_TAG_FTR: begin
        mem_addr = bp_q + size_q - 32'd8;
        wdata    = size_q | 32'(cmd_i.flag);
        wr_en    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_range = mem_addr[31:2] < 30'(DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en && in_range) begin
      mem[mem_addr[IW+1:2]] <= wdata;
    end
    if (rd_en) begin
      raw_q <= mem[mem_addr[IW+1:2]];
      oob_q <= !in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      brk_q <= 32'd16 + CR;
    end else begin
      if (cmd_i.op == CMD_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.op == CMD_GROW_EPI) begin
        brk_q <= brk_q + size_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LATCH: begin
        asize_q <= asize_new;
        zero_q  <= req_i == 16'd0;
        bp_q    <= 32'(off_i);
        res_q   <= 16'd0;
      end
      CMD_WALK_INIT: begin
        bp_q <= 32'd8;
        n_q  <= '0;
      end
      CMD_WALK_STEP: begin
        bp_q <= bp_q + sz;
        n_q  <= n_q + 1'b1;
      end
      CMD_GROW_HDR: begin
        bp_q   <= brk_q;
        size_q <= ext;
      end
      CMD_MRG_RDN: pf_q <= rdata;
      CMD_MRG_CALC: begin
        size_q <= size_q + (rdata[0] ? 32'd0 : nsize) + (pf_q[0] ? 32'd0 : psize);
        bp_q   <= bp_q - (pf_q[0] ? 32'd0 : psize);
      end
      CMD_CARVE_CALC: begin
        res_q <= bp_q[15:0];
        if (rest >= MIN_BLOCK) begin
          size_q  <= 32'(asize_q);
          rest_q  <= rest;
          split_q <= 1'b1;
        end else begin
          size_q  <= bsize;
          split_q <= 1'b0;
        end
      end
      CMD_SPLIT: begin
        bp_q   <= bp_q + size_q;
        size_q <= rest_q;
      end
      CMD_FREE_LOAD: size_q <= sz;
      CMD_RESULT: begin
        pay_q <= cmd_i.flag ? res_q : 16'd0;
        ok_q  <= cmd_i.flag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.clr_last    = clr_q == IW'(DEPTH - 1);
    status_o.req_zero    = zero_q;
    status_o.free_bad    = bp_q[2:0] != 3'd0 || bp_q < 32'd16 || bp_q >= brk_q;
    status_o.walk_stop   = bp_q > brk_q || n_q == NW'(DEPTH);
    status_o.walk_end    = sz == 32'd0;
    status_o.walk_fit    = !rdata[0] && sz >= 32'(asize_q);
    status_o.grow_fail   = (33'(brk_q) + 33'(ext)) > HEAP;
    status_o.free_reject = !rdata[0] || sz < MIN_BLOCK || (bp_q + sz) > brk_q;
    status_o.split       = split_q;
  end

  assign payload_o = pay_q;
  assign ok_o      = ok_q;

endmodule

>>> rtl/core/ffbta_ctrl.sv
module ffbta_ctrl import ffbta_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    in_mode_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  `include "assert_macros.svh"

  typedef enum logic [24:0] {
    ST_CLEAR      = 25'h0000001,
    ST_IDLE       = 25'h0000002,
    ST_CHECK      = 25'h0000004,
    ST_WALK_RD    = 25'h0000008,
    ST_WALK_CHK   = 25'h0000010,
    ST_GROW       = 25'h0000020,
    ST_GROW_FTR   = 25'h0000040,
    ST_GROW_EPI   = 25'h0000080,
    ST_MRG_RDP    = 25'h0000100,
    ST_MRG_RDN    = 25'h0000200,
    ST_MRG_CALC   = 25'h0000400,
    ST_MRG_HDR    = 25'h0000800,
    ST_MRG_FTR    = 25'h0001000,
    ST_CARVE_RD   = 25'h0002000,
    ST_CARVE_CALC = 25'h0004000,
    ST_ALLOC_HDR  = 25'h0008000,
    ST_ALLOC_FTR  = 25'h0010000,
    ST_SPLIT      = 25'h0020000,
    ST_REST_HDR   = 25'h0040000,
    ST_REST_FTR   = 25'h0080000,
    ST_FREE_RD    = 25'h0100000,
    ST_FREE_CHK   = 25'h0200000,
    ST_FREE_HDR   = 25'h0400000,
    ST_FREE_FTR   = 25'h0800000,
    ST_RESP       = 25'h1000000
  } state_e;

  state_e state_q, state_d;
  logic   mode_q, mode_d;
  logic   ok_q, ok_d;
  logic   valid_q, valid_d;
  logic   out_free;

  assign out_free   = !valid_q || out_ready_i;
  assign in_ready_o = state_q == ST_IDLE;
  assign out_valid_o = valid_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    ok_d    = ok_q;
    valid_d = valid_q && !out_ready_i;
    cmd_o   = '{op: CMD_NONE, flag: 1'b0};
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LATCH;
          mode_d   = in_mode_i;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ok_d = 1'b0;
        if (!mode_q) begin
          if (status_i.req_zero) begin
            state_d = ST_RESP;
          end else begin
            cmd_o.op = CMD_WALK_INIT;
            state_d  = ST_WALK_RD;
          end
        end else if (status_i.free_bad) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_FREE_RD;
        end
      end
      ST_WALK_RD: begin
        if (status_i.walk_stop) begin
          state_d = ST_GROW;
        end else begin
          cmd_o.op = CMD_WALK_RD;
          state_d  = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (status_i.walk_end) begin
          state_d = ST_GROW;
        end else if (status_i.walk_fit) begin
          state_d = ST_CARVE_RD;
        end else begin
          cmd_o.op = CMD_WALK_STEP;
          state_d  = ST_WALK_RD;
        end
      end
      ST_GROW: begin
        if (status_i.grow_fail) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.op = CMD_GROW_HDR;
          state_d  = ST_GROW_FTR;
        end
      end
      ST_GROW_FTR: begin
        cmd_o.op = CMD_TAG_FTR;
        state_d  = ST_GROW_EPI;
      end
      ST_GROW_EPI: begin
        cmd_o.op = CMD_GROW_EPI;
        state_d  = ST_MRG_RDP;
      end
      ST_MRG_RDP: begin
        cmd_o.op = CMD_MRG_RDP;
        state_d  = ST_MRG_RDN;
      end
      ST_MRG_RDN: begin
        cmd_o.op = CMD_MRG_RDN;
        state_d  = ST_MRG_CALC;
      end
      ST_MRG_CALC: begin
        cmd_o.op = CMD_MRG_CALC;
        state_d  = ST_MRG_HDR;
      end
      ST_MRG_HDR: begin
        cmd_o.op = CMD_TAG_HDR;
        state_d  = ST_MRG_FTR;
      end
      ST_MRG_FTR: begin
        cmd_o.op = CMD_TAG_FTR;
        if (mode_q) begin
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else begin
          state_d = ST_CARVE_RD;
        end
      end
      ST_CARVE_RD: begin
        cmd_o.op = CMD_HDR_RD;
        state_d  = ST_CARVE_CALC;
      end
      ST_CARVE_CALC: begin
        cmd_o.op = CMD_CARVE_CALC;
        state_d  = ST_ALLOC_HDR;
      end
      ST_ALLOC_HDR: begin
        cmd_o = '{op: CMD_TAG_HDR, flag: 1'b1};
        state_d = ST_ALLOC_FTR;
      end
      ST_ALLOC_FTR: begin
        cmd_o = '{op: CMD_TAG_FTR, flag: 1'b1};
        ok_d  = 1'b1;
        state_d = status_i.split ? ST_SPLIT : ST_RESP;
      end
      ST_SPLIT: begin
        cmd_o.op = CMD_SPLIT;
        state_d  = ST_REST_HDR;
      end
      ST_REST_HDR: begin
        cmd_o.op = CMD_TAG_HDR;
        state_d  = ST_REST_FTR;
      end
      ST_REST_FTR: begin
        cmd_o.op = CMD_TAG_FTR;
        state_d  = ST_RESP;
      end
      ST_FREE_RD: begin
        cmd_o.op = CMD_HDR_RD;
        state_d  = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (status_i.free_reject) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.op = CMD_FREE_LOAD;
          state_d  = ST_FREE_HDR;
        end
      end
      ST_FREE_HDR: begin
        cmd_o.op = CMD_TAG_HDR;
        state_d  = ST_FREE_FTR;
      end
      ST_FREE_FTR: begin
        cmd_o.op = CMD_TAG_FTR;
        state_d  = ST_MRG_RDP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o   = '{op: CMD_RESULT, flag: ok_q};
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q  <= 1'b0;
      ok_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      ok_q    <= ok_d;
      valid_q <= valid_d;
    end
  end

  `FFBTA_ASSERT_NEXT(a_accept_goes_check, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_CHECK, "accepted word did not reach check")
  `FFBTA_ASSERT_NEXT(a_resp_waits, clk_i, rst_ni, state_q == ST_RESP && valid_q && !out_ready_i, state_q == ST_RESP, "result overwrote a pending word")
  `FFBTA_ASSERT(a_idle_no_mem, clk_i, rst_ni, state_q != ST_IDLE || cmd_o.op == CMD_NONE || cmd_o.op == CMD_LATCH, "memory access while idle")

endmodule

>>> rtl/core/first_fit_boundary_tag_allocator_core.sv
// channel   | dir | tdata                                      | tuser
// s_axis    | in  | [15:0] request_size, [31:16] block_offset  | [0] mode (1 = free)
// m_axis    | out | [15:0] payload_offset                       | [0] ok
//
// one word at a time; alloc walks the block headers first fit, and if none fits grows
// the heap, merging with a free block before it, then tags the block and splits off a
// rest of at least MIN_BLOCK bytes; free checks the header, tags it free and merges
// with free neighbours; walk speed is set by the single-port heap memory
// after reset a clearing pass writes the heap image word by word, s_axis_tready low
// a finished result waits in the output register; the next word is taken meanwhile
module first_fit_boundary_tag_allocator_core import ffbta_pkg::*; #(
  parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size, block_offset
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // payload_offset
  output logic        m_axis_tuser   // ok
);

  cmd_t    cmd;
  status_t status;

  ffbta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ffbta_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .req_i     (s_axis_tdata[15:0]),
    .off_i     (s_axis_tdata[31:16]),
    .status_o  (status),
    .payload_o (m_axis_tdata),
    .ok_o      (m_axis_tuser)
  );

endmodule

>>> bench/tb_first_fit_boundary_tag_allocator_core.sv
module tb_first_fit_boundary_tag_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_B  = 65536;
  localparam int unsigned CHUNK_B = 4096;
  localparam int unsigned DEPTH   = HEAP_B / 4;
  localparam int unsigned CHUNK_R = (CHUNK_B + 7) & ~7;
  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic        ok;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int errors = 0;
  int n_alloc_ok = 0;
  int n_alloc_fail = 0;
  int n_free_ok = 0;
  int n_free_bad = 0;
  bit no_idle = 1'b0;
  logic [15:0] live_blocks[$];

  first_fit_boundary_tag_allocator_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  class heap_scoreboard;
    logic [31:0] heap[DEPTH];
    logic [31:0] brk;
    reply_t      pending[$];

    function logic [31:0] rd(logic [31:0] a);
      return (a >> 2) < DEPTH ? heap[a >> 2] : 32'd0;
    endfunction

    function void wr(logic [31:0] a, logic [31:0] v);
      if ((a >> 2) < DEPTH) heap[a >> 2] = v;
    endfunction

    function void tags(logic [31:0] bp, logic [31:0] sz, logic [31:0] al);
      wr(bp - 4, sz | al);
      wr(bp + sz - 8, sz | al);
    endfunction

    function logic [31:0] coalesce(logic [31:0] bp);
      logic [31:0] sz, pf, nh;
      sz = rd(bp - 4) & ~32'd7;
      pf = rd(bp - 8);
      nh = rd(bp + sz - 4);
      if (!nh[0]) sz += nh & ~32'd7;
      if (!pf[0]) begin
        bp -= pf & ~32'd7;
        sz += pf & ~32'd7;
      end
      tags(bp, sz, 0);
      return bp;
    endfunction

    function void clear();
      foreach (heap[i]) heap[i] = '0;
      wr(4, 9);
      wr(8, 9);
      tags(16, CHUNK_R, 0);
      wr(16 + CHUNK_R - 4, 1);
      brk = 16 + CHUNK_R;
      pending.delete();
    endfunction

    function logic [31:0] scan_blocks(logic [31:0] asz);
      logic [31:0] p, h;
      p = 8;
      for (int n = 0; n < DEPTH; n++) begin
        if (p > brk) return 0;
        h = rd(p - 4);
        if ((h & ~32'd7) == 0) return 0;
        if (!h[0] && (h & ~32'd7) >= asz) return p;
        p += h & ~32'd7;
      end
      return 0;
    endfunction

    function void note_request(bit mode, logic [15:0] req, logic [15:0] off);
      reply_t r;
      logic [31:0] asz, p, ext, bsz, h, sz, bp;
      r = '0;
      bp = off;
      if (mode == MODE_ALLOC) begin
        if (req != 0) begin
          asz = req <= 8 ? 32'd16 : 8 * ((32'(req) + 15) / 8);
          p = scan_blocks(asz);
          if (p == 0) begin
            ext = asz > CHUNK_R ? asz : CHUNK_R;
            if (brk + ext <= HEAP_B) begin
              p = brk;
              tags(p, ext, 0);
              wr(p + ext - 4, 1);
              brk += ext;
              p = coalesce(p);
            end
          end
          if (p != 0) begin
            bsz = rd(p - 4) & ~32'd7;
            if (bsz - asz >= 16) begin
              tags(p, asz, 1);
              tags(p + asz, bsz - asz, 0);
            end else begin
              tags(p, bsz, 1);
            end
            r.payload_offset = p[15:0];
            r.ok = 1'b1;
          end
        end
      end else if (bp[2:0] == 0 && bp >= 16 && bp < brk) begin
        h = rd(bp - 4);
        sz = h & ~32'd7;
        if (h[0] && sz >= 16 && bp + sz <= brk) begin
          tags(bp, sz, 0);
          void'(coalesce(bp));
          r.ok = 1'b1;
        end
      end
      pending.push_back(r);
    endfunction

    task check_reply(logic [15:0] off, logic ok);
      reply_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word, offset", off, 0);
        return;
      end
      w = pending.pop_front();
      if (ok !== w.ok) report_mismatch("ok", ok, w.ok);
      if (off !== w.payload_offset) report_mismatch("payload_offset", off, w.payload_offset);
      if (w.ok && w.payload_offset != 0) begin
        n_alloc_ok++;
        live_blocks.push_back(w.payload_offset);
      end
    endtask
  endclass

  heap_scoreboard sb = new();

  task automatic send_word(bit mode, logic [15:0] req, logic [15:0] off);
    while (!no_idle && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {off, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(mode, req, off);
  endtask

  task automatic free_some();
    int k;
    logic [15:0] off;
    if (live_blocks.size() == 0) begin
      send_word(MODE_FREE, 16'($urandom), 16'($urandom));
      return;
    end
    k = $urandom_range(live_blocks.size() - 1);
    off = live_blocks[k];
    live_blocks.delete(k);
    send_word(MODE_FREE, 16'($urandom), off);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
  end

  initial begin
    #300ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int r;
    sb.clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    send_word(MODE_ALLOC, 16'd0, 16'd0);
    send_word(MODE_ALLOC, 16'd1, 16'hffff);
    send_word(MODE_ALLOC, 16'd8, 16'd0);
    send_word(MODE_ALLOC, 16'd9, 16'd0);
    send_word(MODE_ALLOC, 16'd4072, 16'd0);
    send_word(MODE_ALLOC, 16'd24, 16'd0);
    send_word(MODE_ALLOC, 16'hffff, 16'd0);
    send_word(MODE_ALLOC, 16'd20000, 16'd0);
    send_word(MODE_FREE, 16'hffff, 16'd0);
    send_word(MODE_FREE, 16'd0, 16'd12);
    send_word(MODE_FREE, 16'd0, 16'd17);
    send_word(MODE_FREE, 16'd0, 16'hfff8);
    send_word(MODE_FREE, 16'd0, 16'd16);
    send_word(MODE_FREE, 16'd0, 16'd16);
    send_word(MODE_FREE, 16'd0, 16'd8);
    wait_drained();
    repeat (3) free_some();
    repeat (8) send_word(MODE_ALLOC, 16'd30000, 16'd0);
    for (int i = 0; i < 900; i++) begin
      no_idle = (i >= 300 && i < 400);
      if (i == 600) wait_drained();
      r = $urandom_range(99);
      if (r < 50) send_word(MODE_ALLOC, 16'($urandom_range(r < 45 ? 600 : 65535)), 16'($urandom));
      else if (r < 90) free_some();
      else send_word(MODE_FREE, 16'($urandom), 16'($urandom));
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d successful allocations, %0d remaining blocks, heap break %0d",
             n_alloc_ok, live_blocks.size(), sb.brk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffbta_pkg.sv
rtl/core/ffbta_datapath.sv
rtl/core/ffbta_ctrl.sv
rtl/core/first_fit_boundary_tag_allocator_core.sv
bench/tb_first_fit_boundary_tag_allocator_core.sv
